[hdl/appm_pkg.sv]
// package for the ascii ppm p3 parser: result kinds, error codes, phases
// no dependencies
package appm_pkg;

  localparam int unsigned MaxDim      = 4096;
  localparam int unsigned MaxSample   = 65535;
  localparam int unsigned NumLimit    = 65535;
  localparam int unsigned PixelLimit  = 16777216;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_HDR_NUM   = 3'd2,
    ERR_SIZE      = 3'd3,
    ERR_ZERO_MAX  = 3'd4,
    ERR_SAMPLE    = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_e;

  typedef enum logic [8:0] {
    PH_MAGIC  = 9'b000000001,
    PH_WIDTH  = 9'b000000010,
    PH_HEIGHT = 9'b000000100,
    PH_MAXVAL = 9'b000001000,
    PH_RED    = 9'b000010000,
    PH_GREEN  = 9'b000100000,
    PH_BLUE   = 9'b001000000,
    PH_DONE   = 9'b010000000,
    PH_ERROR  = 9'b100000000
  } phase_e;

  // one result as it leaves the front end; samples not yet normalized
  typedef struct packed {
    kind_e       kind;
    err_e        code;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] maxval;
    logic [12:0] width;
    logic [12:0] height;
    logic        last;
  } job_t;

  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] Ch3    = 8'h33;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;

  localparam logic [0:0] CfgMaxDim = 1'b0;
  localparam logic [0:0] CfgMaxPix = 1'b1;

endpackage

[hdl/appm_front.sv]
// front end: tokenizer and header/sample checker, one character per cycle while the queue has room
// depends on appm_pkg
module appm_front import appm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  input  logic [12:0] max_dim_i,
  input  logic [24:0] max_pix_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  phase_e      phase_q, phase_d;
  logic        in_comment_q, in_comment_d;
  logic        in_token_q, in_token_d;
  logic [16:0] accum_q, accum_d;
  logic        invalid_q, invalid_d;
  logic [1:0]  magic_q, magic_d;
  logic [15:0] width_q, width_d, height_q, height_d, maxval_q, maxval_d;
  logic [15:0] red_q, red_d, green_q, green_d;
  logic [23:0] left_q, left_d;
  // text ended inside a token: that token is closed once the queue has room
  logic        eot_q, eot_d;

  logic        is_space, is_digit, fire;
  logic        emit;
  job_t        job;
  logic [20:0] acc_x10;
  logic [3:0]  digit;
  logic [31:0] count;
  logic        size_bad;

  assign fire = in_valid_i && in_ready_o;
  assign in_ready_o = job_ready_i && !eot_q;
  assign is_space = (char_code_i == 8'h20) ||
                    (char_code_i >= 8'h09 && char_code_i <= 8'h0D);
  assign is_digit = (char_code_i >= Ch0) && (char_code_i <= Ch9);
  assign digit = 4'(char_code_i - Ch0);
  assign acc_x10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {17'd0, digit};

  // size check on width and the height token being closed
  assign count = {16'd0, width_q} * {16'd0, accum_q[15:0]};
  assign size_bad = (width_q == 16'd0) || (accum_q[15:0] == 16'd0) ||
                    (width_q > {3'd0, max_dim_i}) || (accum_q[15:0] > {3'd0, max_dim_i}) ||
                    (width_q > 16'(MaxDim)) || (accum_q[15:0] > 16'(MaxDim)) ||
                    (count > {7'd0, max_pix_i}) || (count > PixelLimit);

  // main parser
  always_comb begin
    logic        tok_ok;
    logic        do_finish;
    logic        do_eot;
    logic        tok_char;
    phase_d = phase_q; in_comment_d = in_comment_q; in_token_d = in_token_q;
    accum_d = accum_q; invalid_d = invalid_q; magic_d = magic_q;
    width_d = width_q; height_d = height_q; maxval_d = maxval_q;
    red_d = red_q; green_d = green_q; left_d = left_q; eot_d = eot_q;
    emit = 1'b0;
    job = '0;
    job.maxval = maxval_q;
    tok_ok = 1'b0;
    do_finish = 1'b0;
    do_eot = 1'b0;
    tok_char = 1'b0;

    if (eot_q) begin
      if (job_ready_i) begin
        do_finish = 1'b1;
        do_eot = 1'b1;
      end
    end else if (fire) begin
      if (phase_q != PH_DONE && phase_q != PH_ERROR) begin
        if (in_comment_q) begin
          if (char_code_i == ChLf) in_comment_d = 1'b0;
        end else if (is_space) begin
          do_finish = in_token_q;
        end else if (!in_token_q && char_code_i == ChHash) begin
          in_comment_d = 1'b1;
        end else begin
          in_token_d = 1'b1;
          tok_char = 1'b1;
          if (phase_q == PH_MAGIC) begin
            if (magic_q == 2'd0 && char_code_i == ChP) magic_d = 2'd1;
            else if (magic_q == 2'd1 && char_code_i == Ch3) magic_d = 2'd2;
            else invalid_d = 1'b1;
          end else if (!is_digit) begin
            invalid_d = 1'b1;
          end else if (!invalid_q) begin
            if (acc_x10 > 21'(NumLimit)) invalid_d = 1'b1;
            else accum_d = acc_x10[16:0];
          end
        end
      end
      if (end_of_text_i) begin
        if (tok_char) eot_d = 1'b1;
        else do_eot = 1'b1;
      end
    end

    // finish token
    if (do_finish) begin
      tok_ok = !invalid_q;
      in_token_d = 1'b0; accum_d = '0; invalid_d = 1'b0;
      unique case (phase_q)
        PH_MAGIC: begin
          magic_d = 2'd0;
          if (tok_ok && magic_q == 2'd2) phase_d = PH_WIDTH;
          else begin
            emit = 1'b1; job.kind = KIND_ERROR; job.code = ERR_MAGIC;
            phase_d = PH_ERROR;
          end
        end
        PH_WIDTH: begin
          if (!tok_ok) begin
            emit = 1'b1; job.kind = KIND_ERROR; job.code = ERR_HDR_NUM;
            phase_d = PH_ERROR;
          end else begin
            width_d = accum_q[15:0]; phase_d = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          if (!tok_ok) begin
            emit = 1'b1; job.kind = KIND_ERROR; job.code = ERR_HDR_NUM;
            phase_d = PH_ERROR;
          end else begin
            height_d = accum_q[15:0];
            if (size_bad) begin
              emit = 1'b1; job.kind = KIND_ERROR; job.code = ERR_SIZE;
              phase_d = PH_ERROR;
            end else begin
              left_d = 24'(count - 32'd1);
              phase_d = PH_MAXVAL;
            end
          end
        end
        PH_MAXVAL: begin
          if (!tok_ok || accum_q > 17'(MaxSample)) begin
            emit = 1'b1; job.kind = KIND_ERROR; job.code = ERR_HDR_NUM;
            phase_d = PH_ERROR;
          end else if (accum_q == 17'd0) begin
            emit = 1'b1; job.kind = KIND_ERROR; job.code = ERR_ZERO_MAX;
            phase_d = PH_ERROR;
          end else begin
            maxval_d = accum_q[15:0];
            emit = 1'b1; job.kind = KIND_HEADER;
            job.width = width_q[12:0]; job.height = height_q[12:0];
            phase_d = PH_RED;
          end
        end
        PH_RED, PH_GREEN, PH_BLUE: begin
          if (!tok_ok || accum_q > {1'b0, maxval_q}) begin
            emit = 1'b1; job.kind = KIND_ERROR; job.code = ERR_SAMPLE;
            phase_d = PH_ERROR;
          end else if (phase_q == PH_RED) begin
            red_d = accum_q[15:0]; phase_d = PH_GREEN;
          end else if (phase_q == PH_GREEN) begin
            green_d = accum_q[15:0]; phase_d = PH_BLUE;
          end else begin
            emit = 1'b1; job.kind = KIND_PIXEL;
            job.red = red_q; job.green = green_q; job.blue = accum_q[15:0];
            if (left_q == 24'd0) begin
              job.last = 1'b1; phase_d = PH_DONE;
            end else begin
              left_d = left_q - 24'd1; phase_d = PH_RED;
            end
          end
        end
        default: ;
      endcase
    end

    // end of text: truncation error unless finished or failed
    if (do_eot) begin
      if (phase_d != PH_DONE && phase_d != PH_ERROR) begin
        emit = 1'b1; job = '0; job.kind = KIND_ERROR; job.code = ERR_TRUNCATED;
      end
      phase_d = PH_MAGIC; in_comment_d = 1'b0; in_token_d = 1'b0;
      accum_d = '0; invalid_d = 1'b0; magic_d = '0; width_d = '0;
      height_d = '0; maxval_d = '0; red_d = '0; green_d = '0; left_d = '0;
      eot_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC; in_comment_q <= 1'b0; in_token_q <= 1'b0;
      accum_q <= '0; invalid_q <= 1'b0; magic_q <= '0; width_q <= '0;
      height_q <= '0; maxval_q <= '0; red_q <= '0; green_q <= '0;
      left_q <= '0; eot_q <= 1'b0;
    end else begin
      phase_q <= phase_d; in_comment_q <= in_comment_d; in_token_q <= in_token_d;
      accum_q <= accum_d; invalid_q <= invalid_d; magic_q <= magic_d;
      width_q <= width_d; height_q <= height_d; maxval_q <= maxval_d;
      red_q <= red_d; green_q <= green_d; left_q <= left_d; eot_q <= eot_d;
    end
  end

  assign job_valid_o = emit;
  assign job_o = job;

endmodule

[hdl/appm_queue.sv]
// short queue between the front end and the normalizer
// depends on appm_pkg
module appm_queue import appm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic has_room_o,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign has_room_o  = cnt_q < (PtrW+1)'(QueueDepth);
  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

[hdl/appm_norm.sv]
// back end: normalizes a pixel's three samples with one shared radix-2 divider
// depends on appm_pkg
module appm_norm import appm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output job_t        out_o
);

  typedef enum logic [2:0] {
    NS_IDLE = 3'b001,
    NS_DIV  = 3'b010,
    NS_OUT  = 3'b100
  } nstate_e;

  nstate_e     st_q;
  job_t        job_q;
  logic [1:0]  comp_q;
  logic [4:0]  bit_q;
  logic [32:0] num_q;
  logic [16:0] rem_q;
  logic [31:0] quo_q;
  logic [16:0] trial;
  logic [17:0] rem_sh;
  logic [31:0] quo_n;

  function automatic logic [15:0] nxt_sample(logic [1:0] c, job_t j);
    logic [15:0] s;
    s = (c == 2'd0) ? j.green : j.blue;
    return s;
  endfunction

  assign job_ready_o = (st_q == NS_IDLE);
  assign out_valid_o = (st_q == NS_OUT);
  assign out_o = job_q;

  assign rem_sh = {rem_q, num_q[31]};
  assign trial  = 17'(rem_sh - {2'b0, job_q.maxval});
  assign quo_n  = {quo_q[30:0], rem_sh >= {2'b0, job_q.maxval}};

  // one quotient bit per cycle, 32 bits per component
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= NS_IDLE; comp_q <= '0; bit_q <= '0;
    end else begin
      unique case (st_q)
        NS_IDLE: if (job_valid_i) begin
          st_q <= (job_i.kind == KIND_PIXEL) ? NS_DIV : NS_OUT;
          comp_q <= '0; bit_q <= '0;
        end
        NS_DIV: begin
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'd31) begin
            comp_q <= comp_q + 2'd1;
            if (comp_q == 2'd2) st_q <= NS_OUT;
          end
        end
        NS_OUT: if (out_ready_i) st_q <= NS_IDLE;
        default: st_q <= NS_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (st_q == NS_IDLE && job_valid_i) begin
      job_q <= job_i;
      num_q <= {1'b0, job_i.red, 16'd0} - {17'd0, job_i.red}
               + {18'd0, job_i.maxval[15:1]};
      rem_q <= '0; quo_q <= '0;
    end else if (st_q == NS_DIV) begin
      if (bit_q == 5'd31) begin
        case (comp_q)
          2'd0:    job_q.red   <= (|quo_n[31:16]) ? 16'hFFFF : quo_n[15:0];
          2'd1:    job_q.green <= (|quo_n[31:16]) ? 16'hFFFF : quo_n[15:0];
          default: job_q.blue  <= (|quo_n[31:16]) ? 16'hFFFF : quo_n[15:0];
        endcase
        rem_q <= '0; quo_q <= '0;
        num_q <= {1'b0, nxt_sample(comp_q, job_q), 16'd0}
                 - {17'd0, nxt_sample(comp_q, job_q)}
                 + {18'd0, job_q.maxval[15:1]};
      end else begin
        if (rem_sh >= {2'b0, job_q.maxval}) rem_q <= trial;
        else rem_q <= rem_sh[16:0];
        quo_q <= quo_n;
        num_q <= {num_q[31:0], 1'b0};
      end
    end
  end

endmodule

[hdl/ascii_ppm_p3_parser_core.sv]
// ascii ppm p3 parser top level: tokenizer front end, queue, normalizer
// results: the queue entry and the normalizer register lie between the
// deciding character and the output; pixels also pass the serial divider
// throughput: one character per cycle while the queue has room; input
// waits while a cut-off final token closes; each pixel holds the divider
// reset: async active low, parser to magic, limits to 4096 and 16777216
// depends on appm_pkg, appm_front, appm_queue, appm_norm
module ascii_ppm_p3_parser_core import appm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o,
  output logic [12:0] image_width_o,
  output logic [12:0] image_height_o,
  output logic        last_pixel_o
);

  logic [12:0] max_dim_q;
  logic [24:0] max_pix_q;
  logic        fj_valid, q_room, q_valid, n_ready;
  job_t        fj, qj, nj;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dim_q <= 13'(MaxDim); max_pix_q <= 25'(PixelLimit);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMaxDim) max_dim_q <= cfg_data_i[12:0];
      else max_pix_q <= cfg_data_i;
    end
  end

  appm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .char_code_i, .end_of_text_i,
    .max_dim_i(max_dim_q), .max_pix_i(max_pix_q),
    .job_valid_o(fj_valid), .job_ready_i(q_room), .job_o(fj)
  );

  appm_queue u_queue (
    .clk_i, .rst_ni, .push_i(fj_valid), .push_data_i(fj), .has_room_o(q_room),
    .pop_valid_o(q_valid), .pop_i(q_valid && n_ready), .pop_data_o(qj)
  );

  appm_norm u_norm (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_ready_o(n_ready), .job_i(qj),
    .out_valid_o, .out_ready_i, .out_o(nj)
  );

  assign result_kind_o  = nj.kind;
  assign error_code_o   = nj.code;
  assign red_o          = (nj.kind == KIND_PIXEL) ? nj.red : '0;
  assign green_o        = (nj.kind == KIND_PIXEL) ? nj.green : '0;
  assign blue_o         = (nj.kind == KIND_PIXEL) ? nj.blue : '0;
  assign image_width_o  = nj.width;
  assign image_height_o = nj.height;
  assign last_pixel_o   = nj.last;

  // a front result is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) fj_valid |-> q_room)
    else $error("push into full queue");
  // results carry an error code exactly when they are errors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code mismatch");
  // header results always report a nonzero width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_HEADER) |-> (image_width_o != 13'd0))
    else $error("header with zero width");

endmodule
